// ===== hw/rtl/mpsm_pkg.sv =====
package mpsm_pkg;

    localparam int MAX_NODES = 1024;
    localparam int ALPHABET  = 26;
    localparam int SYM_W     = 5;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int SLOT_W    = $clog2(ALPHABET + 1);
    localparam int ROW_W     = ALPHABET * NODE_W;
    localparam int QDEPTH    = 4;
    localparam int QA_W      = $clog2(QDEPTH);
    localparam int QC_W      = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_BUILD = 2'd1,
        MODE_SCAN  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_QUERY   = 2'd0,
        KIND_BUILT   = 2'd1,
        KIND_REJECT  = 2'd2,
        KIND_CLEARED = 2'd3
    } kind_t;

    typedef struct packed {
        mode_t            mode;
        logic [SYM_W-1:0] letter;
        logic             last;
        logic             sym_ok;
    } cmd_t;

    function automatic logic [NODE_W-1:0] kid(input logic [ROW_W-1:0] row,
                                              input int unsigned sym);
        return row[NODE_W*sym +: NODE_W];
    endfunction

endpackage

// ===== hw/rtl/mpsm_ram.sv =====
module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/mpsm_front.sv =====
module mpsm_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  logic [1:0]     mode,
    input  logic [4:0]     letter,
    input  logic           last,
    input  logic           pop,
    output logic           avail,
    output mpsm_pkg::cmd_t head
);
    import mpsm_pkg::*;

    cmd_t            mem_reg [QDEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    cmd_t            incoming;
    logic            push;
    logic            take;

    always_comb
    begin
        incoming.mode   = mode_t'(mode);
        incoming.letter = letter;
        incoming.last   = last;
        incoming.sym_ok = (int'(letter) < ALPHABET);
    end

    assign cmd_ready = (count_reg != QC_W'(QDEPTH));
    assign avail     = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign push      = cmd_valid && cmd_ready;
    assign take      = pop && avail;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QC_W'(push) - QC_W'(take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ===== hw/rtl/mpsm_engine.sv =====
module mpsm_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_avail,
    input  mpsm_pkg::cmd_t cmd_head,
    output logic           cmd_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [1:0]     kind,
    output logic           hit
);
    import mpsm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_A_CHK, ST_A_NEW, ST_A_LAST,
        ST_B_POP, ST_B_Q, ST_B_ROW, ST_B_SLOT, ST_B_WALK, ST_B_WCHK,
        ST_B_SET, ST_B_TERM, ST_S_WALK, ST_S_CHK, ST_S_TRD, ST_S_TEND,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [NODE_W-1:0]   ins_cur_reg, ins_cur_next;
    logic                ovf_reg, ovf_next;
    logic [NODE_W-1:0]   scan_cur_reg, scan_cur_next;
    logic                seen_reg, seen_next;
    logic [CNT_W-1:0]    node_cnt_reg, node_cnt_next;
    logic                root_ok_reg, root_ok_next;
    logic                root_term_reg, root_term_next;
    logic [CNT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    tail_reg, tail_next;
    logic [NODE_W-1:0]   u_reg, u_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [NODE_W-1:0]   fu_reg, fu_next;
    logic [SLOT_W-1:0]   s_reg, s_next;
    logic [NODE_W-1:0]   c_reg, c_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [NODE_W-1:0]   f_reg, f_next;
    kind_t               pk_kind_reg, pk_kind_next;
    logic                pk_hit_reg, pk_hit_next;
    logic                res_valid_reg, res_valid_next;
    kind_t               kind_reg, kind_next;
    logic                hit_reg, hit_next;

    logic                ch_we, ch_re;
    logic [NODE_W-1:0]   ch_wa, ch_ra;
    logic [ROW_W-1:0]    ch_wd, ch_rd;
    logic                fl_we, fl_re;
    logic [NODE_W-1:0]   fl_wa, fl_ra, fl_wd, fl_rd;
    logic                tm_we, tm_re;
    logic [NODE_W-1:0]   tm_wa, tm_ra;
    logic                tm_wd, tm_rd;
    logic                q_we, q_re;
    logic [NODE_W-1:0]   q_wa, q_ra, q_wd, q_rd;

    mpsm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_child (
        .clk(clk), .wr_en(ch_we), .wr_addr(ch_wa), .wr_data(ch_wd),
        .rd_en(ch_re), .rd_addr(ch_ra), .rd_data(ch_rd)
    );

    mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
        .clk(clk), .wr_en(fl_we), .wr_addr(fl_wa), .wr_data(fl_wd),
        .rd_en(fl_re), .rd_addr(fl_ra), .rd_data(fl_rd)
    );

    mpsm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_term (
        .clk(clk), .wr_en(tm_we), .wr_addr(tm_wa), .wr_data(tm_wd),
        .rd_en(tm_re), .rd_addr(tm_ra), .rd_data(tm_rd)
    );

    mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
        .rd_en(q_re), .rd_addr(q_ra), .rd_data(q_rd)
    );

    assign res_valid = res_valid_reg;
    assign kind      = kind_reg;
    assign hit       = hit_reg;

    always_comb
    begin
        logic [ROW_W-1:0]  row;
        logic [NODE_W-1:0] k;
        logic              t;

        row = '0;
        k   = '0;
        t   = 1'b0;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ins_cur_next   = ins_cur_reg;
        ovf_next       = ovf_reg;
        scan_cur_next  = scan_cur_reg;
        seen_next      = seen_reg;
        node_cnt_next  = node_cnt_reg;
        root_ok_next   = root_ok_reg;
        root_term_next = root_term_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        u_next         = u_reg;
        row_next       = row_reg;
        fu_next        = fu_reg;
        s_next         = s_reg;
        c_next         = c_reg;
        node_next      = node_reg;
        f_next         = f_reg;
        pk_kind_next   = pk_kind_reg;
        pk_hit_next    = pk_hit_reg;
        kind_next      = kind_reg;
        hit_next       = hit_reg;
        res_valid_next = res_valid_reg && !res_ready;
        cmd_pop        = 1'b0;

        ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_re = 1'b0; ch_ra = '0;
        fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_re = 1'b0; fl_ra = '0;
        tm_we = 1'b0; tm_wa = '0; tm_wd = 1'b0; tm_re = 1'b0; tm_ra = '0;
        q_we  = 1'b0; q_wa  = '0; q_wd  = '0; q_re  = 1'b0; q_ra  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_head;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (cmd_reg.mode)
                    MODE_ADD:
                    begin
                        if (!ovf_reg && cmd_reg.sym_ok)
                        begin
                            ch_re      = 1'b1;
                            ch_ra      = ins_cur_reg;
                            state_next = ST_A_CHK;
                        end
                        else
                        begin
                            state_next = ST_A_LAST;
                        end
                    end
                    MODE_BUILD:
                    begin
                        q_we       = 1'b1;
                        q_wa       = '0;
                        q_wd       = '0;
                        head_next  = '0;
                        tail_next  = CNT_W'(1);
                        state_next = ST_B_POP;
                    end
                    MODE_SCAN:
                    begin
                        if (cmd_reg.sym_ok)
                        begin
                            node_next  = scan_cur_reg;
                            state_next = ST_S_WALK;
                        end
                        else
                        begin
                            node_next  = '0;
                            state_next = ST_S_TRD;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        node_cnt_next  = CNT_W'(1);
                        ins_cur_next   = '0;
                        ovf_next       = 1'b0;
                        scan_cur_next  = '0;
                        seen_next      = 1'b0;
                        root_ok_next   = 1'b0;
                        root_term_next = 1'b0;
                        pk_kind_next   = KIND_CLEARED;
                        pk_hit_next    = 1'b0;
                        state_next     = ST_EMIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_A_CHK:
            begin
                row = (ins_cur_reg == '0 && !root_ok_reg) ? '0 : ch_rd;
                k   = kid(row, int'(cmd_reg.letter));
                if (k != '0)
                begin
                    ins_cur_next = k;
                    state_next   = ST_A_LAST;
                end
                else if (node_cnt_reg < CNT_W'(MAX_NODES))
                begin
                    row[NODE_W*int'(cmd_reg.letter) +: NODE_W] = node_cnt_reg[NODE_W-1:0];
                    ch_we = 1'b1;
                    ch_wa = ins_cur_reg;
                    ch_wd = row;
                    if (ins_cur_reg == '0)
                    begin
                        root_ok_next = 1'b1;
                    end
                    fl_we         = 1'b1;
                    fl_wa         = node_cnt_reg[NODE_W-1:0];
                    fl_wd         = '0;
                    tm_we         = 1'b1;
                    tm_wa         = node_cnt_reg[NODE_W-1:0];
                    tm_wd         = 1'b0;
                    c_next        = node_cnt_reg[NODE_W-1:0];
                    ins_cur_next  = node_cnt_reg[NODE_W-1:0];
                    node_cnt_next = node_cnt_reg + 1'b1;
                    state_next    = ST_A_NEW;
                end
                else
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_A_LAST;
                end
            end
            ST_A_NEW:
            begin
                ch_we      = 1'b1;
                ch_wa      = c_reg;
                ch_wd      = '0;
                state_next = ST_A_LAST;
            end
            ST_A_LAST:
            begin
                state_next = ST_IDLE;
                if (cmd_reg.last)
                begin
                    if (!ovf_reg)
                    begin
                        if (ins_cur_reg == '0)
                        begin
                            root_term_next = 1'b1;
                        end
                        else
                        begin
                            tm_we = 1'b1;
                            tm_wa = ins_cur_reg;
                            tm_wd = 1'b1;
                        end
                    end
                    else
                    begin
                        pk_kind_next = KIND_REJECT;
                        pk_hit_next  = 1'b0;
                        state_next   = ST_EMIT;
                    end
                    ins_cur_next = '0;
                    ovf_next     = 1'b0;
                end
            end
            ST_B_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    ins_cur_next  = '0;
                    ovf_next      = 1'b0;
                    scan_cur_next = '0;
                    seen_next     = 1'b0;
                    pk_kind_next  = KIND_BUILT;
                    pk_hit_next   = 1'b0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    q_re       = 1'b1;
                    q_ra       = head_reg[NODE_W-1:0];
                    head_next  = head_reg + 1'b1;
                    state_next = ST_B_Q;
                end
            end
            ST_B_Q:
            begin
                u_next     = q_rd;
                ch_re      = 1'b1;
                ch_ra      = q_rd;
                fl_re      = 1'b1;
                fl_ra      = q_rd;
                state_next = ST_B_ROW;
            end
            ST_B_ROW:
            begin
                row_next   = (u_reg == '0 && !root_ok_reg) ? '0 : ch_rd;
                fu_next    = (u_reg == '0) ? '0 : fl_rd;
                s_next     = '0;
                state_next = ST_B_SLOT;
            end
            ST_B_SLOT:
            begin
                if (s_reg == SLOT_W'(ALPHABET))
                begin
                    state_next = ST_B_POP;
                end
                else
                begin
                    k = kid(row_reg, int'(s_reg));
                    if (k == '0)
                    begin
                        s_next = s_reg + 1'b1;
                    end
                    else
                    begin
                        c_next = k;
                        if (u_reg == '0)
                        begin
                            f_next     = '0;
                            state_next = ST_B_SET;
                        end
                        else
                        begin
                            node_next  = fu_reg;
                            state_next = ST_B_WALK;
                        end
                    end
                end
            end
            ST_B_WALK:
            begin
                ch_re      = 1'b1;
                ch_ra      = node_reg;
                fl_re      = 1'b1;
                fl_ra      = node_reg;
                state_next = ST_B_WCHK;
            end
            ST_B_WCHK:
            begin
                row = (node_reg == '0 && !root_ok_reg) ? '0 : ch_rd;
                k   = kid(row, int'(s_reg));
                if (node_reg != '0 && k == '0)
                begin
                    node_next  = fl_rd;
                    state_next = ST_B_WALK;
                end
                else
                begin
                    f_next     = k;
                    state_next = ST_B_SET;
                end
            end
            ST_B_SET:
            begin
                fl_we      = 1'b1;
                fl_wa      = c_reg;
                fl_wd      = f_reg;
                tm_re      = 1'b1;
                tm_ra      = f_reg;
                state_next = ST_B_TERM;
            end
            ST_B_TERM:
            begin
                t = (f_reg == '0) ? root_term_reg : tm_rd;
                if (t)
                begin
                    tm_we = 1'b1;
                    tm_wa = c_reg;
                    tm_wd = 1'b1;
                end
                if (tail_reg < CNT_W'(MAX_NODES))
                begin
                    q_we      = 1'b1;
                    q_wa      = tail_reg[NODE_W-1:0];
                    q_wd      = c_reg;
                    tail_next = tail_reg + 1'b1;
                end
                s_next     = s_reg + 1'b1;
                state_next = ST_B_SLOT;
            end
            ST_S_WALK:
            begin
                ch_re      = 1'b1;
                ch_ra      = node_reg;
                fl_re      = 1'b1;
                fl_ra      = node_reg;
                state_next = ST_S_CHK;
            end
            ST_S_CHK:
            begin
                row = (node_reg == '0 && !root_ok_reg) ? '0 : ch_rd;
                k   = kid(row, int'(cmd_reg.letter));
                if (node_reg != '0 && k == '0)
                begin
                    node_next  = fl_rd;
                    state_next = ST_S_WALK;
                end
                else
                begin
                    node_next  = k;
                    state_next = ST_S_TRD;
                end
            end
            ST_S_TRD:
            begin
                tm_re      = 1'b1;
                tm_ra      = node_reg;
                state_next = ST_S_TEND;
            end
            ST_S_TEND:
            begin
                t = seen_reg | ((node_reg == '0) ? root_term_reg : tm_rd);
                if (cmd_reg.last)
                begin
                    pk_kind_next  = KIND_QUERY;
                    pk_hit_next   = t;
                    scan_cur_next = '0;
                    seen_next     = 1'b0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    scan_cur_next = node_reg;
                    seen_next     = t;
                    state_next    = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = pk_kind_reg;
                    hit_next       = pk_hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            ins_cur_reg   <= '0;
            ovf_reg       <= 1'b0;
            scan_cur_reg  <= '0;
            seen_reg      <= 1'b0;
            node_cnt_reg  <= CNT_W'(1);
            root_ok_reg   <= 1'b0;
            root_term_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            u_reg         <= '0;
            row_reg       <= '0;
            fu_reg        <= '0;
            s_reg         <= '0;
            c_reg         <= '0;
            node_reg      <= '0;
            f_reg         <= '0;
            pk_kind_reg   <= KIND_QUERY;
            pk_hit_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            kind_reg      <= KIND_QUERY;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            ins_cur_reg   <= ins_cur_next;
            ovf_reg       <= ovf_next;
            scan_cur_reg  <= scan_cur_next;
            seen_reg      <= seen_next;
            node_cnt_reg  <= node_cnt_next;
            root_ok_reg   <= root_ok_next;
            root_term_reg <= root_term_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            u_reg         <= u_next;
            row_reg       <= row_next;
            fu_reg        <= fu_next;
            s_reg         <= s_next;
            c_reg         <= c_next;
            node_reg      <= node_next;
            f_reg         <= f_next;
            pk_kind_reg   <= pk_kind_next;
            pk_hit_reg    <= pk_hit_next;
            res_valid_reg <= res_valid_next;
            kind_reg      <= kind_next;
            hit_reg       <= hit_next;
        end
    end

    a_node_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        node_cnt_reg >= CNT_W'(1) && node_cnt_reg <= CNT_W'(MAX_NODES))
        else $error("node count out of range");

    a_ins_cur_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(ins_cur_reg) < node_cnt_reg)
        else $error("insert cursor past allocated nodes");

    a_scan_cur_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(scan_cur_reg) < node_cnt_reg)
        else $error("scan cursor past allocated nodes");

    a_bfs_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg && tail_reg <= CNT_W'(MAX_NODES))
        else $error("breadth first queue pointers crossed");

endmodule

// ===== hw/rtl/multi_pattern_string_matcher.sv =====
// Each item runs through the sequencer states, with extra walk steps for each failure
// link followed during a scan letter; its result is registered once the output is free.
// A build walks the trie breadth first over every letter slot of every node, following
// failure links, all on one read port of the row-wide child memory.
// A 4-entry command queue keeps accepting items while the sequencer is busy, until it is full.
// Reset (async, active low) leaves an empty trie at once; no clearing pass.
module multi_pattern_string_matcher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [1:0] mode,
    input  logic [4:0] letter,
    input  logic       last,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [1:0] kind,
    output logic       hit
);
    import mpsm_pkg::*;

    cmd_t head;
    logic avail;
    logic pop;

    mpsm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .mode(mode), .letter(letter), .last(last),
        .pop(pop), .avail(avail), .head(head)
    );

    mpsm_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .cmd_avail(avail), .cmd_head(head), .cmd_pop(pop),
        .res_valid(res_valid), .res_ready(res_ready),
        .kind(kind), .hit(hit)
    );

endmodule
